// ===== hdl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the seven-segment display command encoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_DECIMAL = 2'd1;
  localparam logic [1:0] CMD_DIGIT   = 2'd2;
  localparam logic [1:0] CMD_BRIGHT  = 2'd3;

  localparam logic [7:0] BYTE_DATA_AUTO  = 8'h40;
  localparam logic [7:0] BYTE_DATA_FIXED = 8'h44;
  localparam logic [7:0] BYTE_ADDR       = 8'hC0;
  localparam logic [7:0] BYTE_DISP_ON    = 8'h88;
  localparam logic [7:0] SEG_COLON       = 8'h80;
  localparam logic [7:0] SEG_MINUS       = 8'h40;

  localparam logic [13:0] MAG_NEG_MAX = 14'd999;
  localparam logic [13:0] MAG_POS_MAX = 14'd9999;
  localparam logic [2:0]  LEVEL_MAX   = 3'd7;

  localparam logic [2:0] CNT_FULL   = 3'd6;
  localparam logic [2:0] CNT_DIGIT  = 3'd3;
  localparam logic [2:0] CNT_BRIGHT = 3'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] number;
    logic [7:0]         digit_code;
    logic [7:0]         position;
    logic [7:0]         level;
  } in_req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } out_rsp_t;

  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      count;
  } frame_t;

  function automatic logic [7:0] seg_lookup(input logic [7:0] code);
    logic [7:0] seg;
    case (code)
      8'd0:    seg = 8'h3f;
      8'd1:    seg = 8'h06;
      8'd2:    seg = 8'h5b;
      8'd3:    seg = 8'h4f;
      8'd4:    seg = 8'h66;
      8'd5:    seg = 8'h6d;
      8'd6:    seg = 8'h7d;
      8'd7:    seg = 8'h07;
      8'd8:    seg = 8'h7f;
      8'd9:    seg = 8'h6f;
      8'd10:   seg = 8'h77;
      8'd11:   seg = 8'h7c;
      8'd12:   seg = 8'h39;
      8'd13:   seg = 8'h5e;
      8'd14:   seg = 8'h79;
      8'd15:   seg = 8'h71;
      8'd16:   seg = 8'h3e;
      8'd17:   seg = 8'h38;
      8'd18:   seg = 8'h76;
      8'd19:   seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== hdl/ssd_frame_pipe.sv =====
// ----------------------------------------------------------------------------
// ssd_frame_pipe
// Seven-stage pipeline: clamp, decimal split and segment mapping into a frame.
// ----------------------------------------------------------------------------
module ssd_frame_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ssd_pkg::in_req_t in_req,
  input  logic            colon_on,
  input  logic            frame_ready,
  output logic            frame_valid,
  output ssd_pkg::frame_t frame
);

  localparam int NSTG = 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        neg;
    logic [13:0] val;
    logic [3:0]  d_thou;
    logic [3:0]  d_hund;
    logic [3:0]  d_tens;
    logic [3:0]  d_ones;
    logic [7:0]  code;
    logic [1:0]  pos;
    logic [2:0]  lvl;
  } work_t;

  work_t           stg_r   [NSTG];
  work_t           stg_nxt [NSTG];
  logic [NSTG-1:0] stg_vld_r;
  logic            vld0_nxt;
  ssd_pkg::frame_t frm_r;
  ssd_pkg::frame_t frm_nxt;
  logic            frm_vld_r;
  logic [NSTG:0]   adv;

  logic [15:0] neg_mag;
  logic [28:0] prod_thou;
  logic [22:0] prod_hund;
  logic [3:0]  tens;
  logic        drop;
  logic [7:0]  seg_d1;
  logic [7:0]  seg_dig;

  always_comb begin
    adv[NSTG] = !frm_vld_r || frame_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !stg_vld_r[k] || adv[k+1];
    end
  end

  assign busy = !adv[0];

  // stage 0: capture and clamp
  always_comb begin
    neg_mag = (~in_req.number) + 16'sd1;
    drop    = (in_req.command == ssd_pkg::CMD_DIGIT) && (|in_req.position[7:2]);
    vld0_nxt = start && !busy && !drop;
    stg_nxt[0]        = '0;
    stg_nxt[0].cmd    = in_req.command;
    stg_nxt[0].neg    = in_req.number[15];
    stg_nxt[0].code   = in_req.digit_code;
    stg_nxt[0].pos    = in_req.position[1:0];
    stg_nxt[0].lvl    = (|in_req.level[7:3]) ? ssd_pkg::LEVEL_MAX : in_req.level[2:0];
    if (in_req.number[15]) begin
      stg_nxt[0].val = (neg_mag > {2'b00, ssd_pkg::MAG_NEG_MAX}) ?
                       ssd_pkg::MAG_NEG_MAX : neg_mag[13:0];
    end else begin
      stg_nxt[0].val = (in_req.number > $signed({2'b00, ssd_pkg::MAG_POS_MAX})) ?
                       ssd_pkg::MAG_POS_MAX : in_req.number[13:0];
    end
  end

  // stage 1: thousands by reciprocal, floor(x * 16778 / 2^24) for x < 10000
  always_comb begin
    prod_thou = 29'(stg_r[0].val) * 29'd16778;
    stg_nxt[1] = stg_r[0];
    stg_nxt[1].d_thou = prod_thou[27:24];
  end

  // stage 2: remainder below 1000
  always_comb begin
    stg_nxt[2] = stg_r[1];
    stg_nxt[2].val = stg_r[1].val - (14'(stg_r[1].d_thou) * 14'd1000);
  end

  // stage 3: hundreds by reciprocal, floor(x * 5243 / 2^19) for x < 1000
  always_comb begin
    prod_hund = 23'(stg_r[2].val[9:0]) * 23'd5243;
    stg_nxt[3] = stg_r[2];
    stg_nxt[3].d_hund = prod_hund[22:19];
  end

  // stage 4: remainder below 100
  always_comb begin
    stg_nxt[4] = stg_r[3];
    stg_nxt[4].val = stg_r[3].val - (14'(stg_r[3].d_hund) * 14'd100);
  end

  // stage 5: tens and ones
  always_comb begin
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (stg_r[4].val[6:0] >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    stg_nxt[5] = stg_r[4];
    stg_nxt[5].d_tens = tens;
    stg_nxt[5].d_ones = 4'(stg_r[4].val[6:0] - (7'(tens) * 7'd10));
  end

  // stage 6: segment mapping and frame assembly
  always_comb begin
    seg_d1  = ssd_pkg::seg_lookup({4'd0, stg_r[5].d_hund}) |
              (colon_on ? ssd_pkg::SEG_COLON : 8'h00);
    seg_dig = ssd_pkg::seg_lookup(stg_r[5].code) |
              ((colon_on && (stg_r[5].pos == 2'd1)) ? ssd_pkg::SEG_COLON : 8'h00);
    frm_nxt = '0;
    case (stg_r[5].cmd)
      ssd_pkg::CMD_CLEAR: begin
        frm_nxt.bytes[0] = ssd_pkg::BYTE_DATA_AUTO;
        frm_nxt.bytes[1] = ssd_pkg::BYTE_ADDR;
        frm_nxt.count    = ssd_pkg::CNT_FULL;
      end
      ssd_pkg::CMD_DECIMAL: begin
        frm_nxt.bytes[0] = ssd_pkg::BYTE_DATA_AUTO;
        frm_nxt.bytes[1] = ssd_pkg::BYTE_ADDR;
        frm_nxt.bytes[2] = stg_r[5].neg ? ssd_pkg::SEG_MINUS :
                           ssd_pkg::seg_lookup({4'd0, stg_r[5].d_thou});
        frm_nxt.bytes[3] = seg_d1;
        frm_nxt.bytes[4] = ssd_pkg::seg_lookup({4'd0, stg_r[5].d_tens});
        frm_nxt.bytes[5] = ssd_pkg::seg_lookup({4'd0, stg_r[5].d_ones});
        frm_nxt.count    = ssd_pkg::CNT_FULL;
      end
      ssd_pkg::CMD_DIGIT: begin
        frm_nxt.bytes[0] = ssd_pkg::BYTE_DATA_FIXED;
        frm_nxt.bytes[1] = ssd_pkg::BYTE_ADDR | {6'd0, stg_r[5].pos};
        frm_nxt.bytes[2] = seg_dig;
        frm_nxt.count    = ssd_pkg::CNT_DIGIT;
      end
      default: begin
        frm_nxt.bytes[0] = ssd_pkg::BYTE_DISP_ON | {5'd0, stg_r[5].lvl};
        frm_nxt.count    = ssd_pkg::CNT_BRIGHT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
      frm_vld_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        stg_vld_r[0] <= vld0_nxt;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          stg_vld_r[k] <= stg_vld_r[k-1];
        end
      end
      if (adv[NSTG]) begin
        frm_vld_r <= stg_vld_r[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (adv[NSTG]) begin
      frm_r <= frm_nxt;
    end
  end

  assign frame_valid = frm_vld_r;
  assign frame       = frm_r;

endmodule

// ===== hdl/seven_segment_display_command_encoder.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder
// Turns display commands into the byte frames of a four-digit display.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_req and raise start; the request is taken on a clock
//   edge where start is high and busy is low. busy rises only when the
//   pipeline is full.
//   Output: each byte appears on out_rsp for one cycle with out_strobe high.
//   The receiver cannot stall; bytes of one request come on consecutive
//   cycles, the final one flagged by last.
//   Config: cfg_we with cfg_wdata sets the colon bit; write while idle.
//   Path: a request passes the frame pipeline, the serializer frame register
//   and the output register. Throughput: a request enters every cycle while
//   the pipeline has room; sustained rate is set by the byte serializer at
//   one byte per cycle: six bytes for clear and decimal, three for a digit,
//   one for brightness. A digit request at a position above 3 emits nothing.
//   Reset: rst_n low clears all valid bits, the serializer and the colon bit.
// ----------------------------------------------------------------------------
module seven_segment_display_command_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ssd_pkg::in_req_t  in_req,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              out_strobe,
  output ssd_pkg::out_rsp_t out_rsp
);

  logic              colon_r;
  logic              frm_valid;
  logic              frm_ready;
  ssd_pkg::frame_t   frm;

  ssd_pkg::frame_t   ser_frm_r;
  logic              ser_vld_r;
  logic [2:0]        ser_idx_r;
  logic              ser_last;

  logic              out_strobe_r;
  ssd_pkg::out_rsp_t out_rsp_r;
  ssd_pkg::out_rsp_t out_rsp_nxt;

  ssd_frame_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .colon_on    (colon_r),
    .frame_ready (frm_ready),
    .frame_valid (frm_valid),
    .frame       (frm)
  );

  assign ser_last  = ser_idx_r == (ser_frm_r.count - 3'd1);
  assign frm_ready = !ser_vld_r || ser_last;

  always_comb begin
    out_rsp_nxt.data_byte   = ser_frm_r.bytes[ser_idx_r];
    out_rsp_nxt.frame_start = ser_idx_r[2:1] == 2'b00;
    out_rsp_nxt.frame_end   = (ser_idx_r == 3'd0) || ser_last;
    out_rsp_nxt.last        = ser_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_r      <= 1'b0;
      ser_vld_r    <= 1'b0;
      ser_idx_r    <= 3'd0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        colon_r <= cfg_wdata;
      end
      out_strobe_r <= ser_vld_r;
      if (frm_valid && frm_ready) begin
        ser_vld_r <= 1'b1;
        ser_idx_r <= 3'd0;
      end else if (ser_vld_r) begin
        if (ser_last) begin
          ser_vld_r <= 1'b0;
        end else begin
          ser_idx_r <= ser_idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      ser_frm_r <= frm;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> (ser_idx_r < ser_frm_r.count))
    else $error("serializer index beyond frame length");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> (ser_frm_r.count == ssd_pkg::CNT_FULL ||
                   ser_frm_r.count == ssd_pkg::CNT_DIGIT ||
                   ser_frm_r.count == ssd_pkg::CNT_BRIGHT))
    else $error("illegal frame byte count");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_rsp_r.last) |=> out_strobe_r)
    else $error("gap inside a request's byte stream");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && $past(out_strobe_r) && $past(out_rsp_r.last)) |->
      (out_rsp_r.frame_start && out_rsp_r.frame_end))
    else $error("request does not open with a complete command frame");

endmodule

// ===== tb/seven_segment_display_command_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder_checker
// Watches the request, configuration and byte channels of the display
// command encoder. It predicts the byte frames of every accepted request
// and compares each strobed byte, field by field, with the oldest one that
// is still due. A mismatch count goes back to the test top.
// ----------------------------------------------------------------------------
module seven_segment_display_command_encoder_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ssd_pkg::in_req_t  in_req,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              out_strobe,
  input  ssd_pkg::out_rsp_t out_rsp,
  input  logic              drain,
  output int                fail_count,
  output int                pending,
  output int                bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_COUNT = 21;
  localparam logic [0:GLYPH_COUNT-1][7:0] GLYPHS = {
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
    8'h3e, 8'h38, 8'h76, 8'h40, 8'h00
  };

  ssd_pkg::out_rsp_t expected_bytes[$];
  logic              colon_copy;
  logic              drained;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic s, input logic e,
                                    input logic l);
    ssd_pkg::out_rsp_t rsp;
    rsp.data_byte   = b;
    rsp.frame_start = s;
    rsp.frame_end   = e;
    rsp.last        = l;
    expected_bytes.push_back(rsp);
  endfunction

  function automatic void encode_command(input ssd_pkg::in_req_t r);
    logic [7:0] digits [4];
    logic [7:0] seg;
    logic [2:0] lvl;
    logic       neg;
    int         mag;
    int         i;
    case (r.command)
      ssd_pkg::CMD_CLEAR, ssd_pkg::CMD_DECIMAL: begin
        for (i = 0; i < 4; i++) digits[i] = 8'h00;
        if (r.command == ssd_pkg::CMD_DECIMAL) begin
          neg = r.number[15];
          mag = neg ? 32'd65536 - {16'd0, r.number} : {16'd0, r.number};
          if (neg && mag > 999) mag = 999;
          if (!neg && mag > 9999) mag = 9999;
          for (i = 3; i >= 0; i--) begin
            digits[i] = GLYPHS[mag % 10];
            mag = mag / 10;
          end
          if (neg) digits[0] = ssd_pkg::SEG_MINUS;
          if (colon_copy) digits[1] = digits[1] | ssd_pkg::SEG_COLON;
        end
        push_byte(ssd_pkg::BYTE_DATA_AUTO, 1'b1, 1'b1, 1'b0);
        push_byte(ssd_pkg::BYTE_ADDR, 1'b1, 1'b0, 1'b0);
        for (i = 0; i < 4; i++) push_byte(digits[i], 1'b0, i == 3, i == 3);
      end
      ssd_pkg::CMD_DIGIT: begin
        if (r.position <= 8'd3) begin
          seg = (r.digit_code < GLYPH_COUNT) ? GLYPHS[r.digit_code] : 8'h00;
          if (colon_copy && r.position == 8'd1) seg = seg | ssd_pkg::SEG_COLON;
          push_byte(ssd_pkg::BYTE_DATA_FIXED, 1'b1, 1'b1, 1'b0);
          push_byte(ssd_pkg::BYTE_ADDR | r.position, 1'b1, 1'b0, 1'b0);
          push_byte(seg, 1'b0, 1'b1, 1'b1);
        end
      end
      default: begin
        lvl = (r.level > 8'd7) ? ssd_pkg::LEVEL_MAX : r.level[2:0];
        push_byte(ssd_pkg::BYTE_DISP_ON | {5'd0, lvl}, 1'b1, 1'b1, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    ssd_pkg::out_rsp_t want;
    if (!rst_n) begin
      colon_copy = 1'b0;
      drained = 1'b0;
      expected_bytes.delete();
      fail_count = 0;
      bytes_checked = 0;
      pending <= 0;
    end else begin
      if (cfg_we) colon_copy = cfg_wdata;
      if (start && !busy) encode_command(in_req);
      if (out_strobe) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_rsp.data_byte));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_rsp.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte got %02h want %02h",
                                      out_rsp.data_byte, want.data_byte));
          if (out_rsp.frame_start !== want.frame_start)
            report_mismatch($sformatf("frame_start got %b want %b on byte %02h",
                                      out_rsp.frame_start, want.frame_start,
                                      want.data_byte));
          if (out_rsp.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %b want %b on byte %02h",
                                      out_rsp.frame_end, want.frame_end,
                                      want.data_byte));
          if (out_rsp.last !== want.last)
            report_mismatch($sformatf("last got %b want %b on byte %02h",
                                      out_rsp.last, want.last, want.data_byte));
        end
      end
      if (drain && !drained) begin
        drained = 1'b1;
        if (expected_bytes.size() != 0)
          report_mismatch($sformatf("%0d expected bytes never arrived",
                                    expected_bytes.size()));
      end
      pending <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/seven_segment_display_command_encoder_test.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder_test
// Drives display commands into the encoder: a directed set of range edges,
// every command and the colon cases, then random requests under three
// sender idle profiles with the colon bit changed between phases. A checker
// beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module seven_segment_display_command_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  ssd_pkg::in_req_t  in_req;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              out_strobe;
  ssd_pkg::out_rsp_t out_rsp;
  logic              drain;
  int                fail_count;
  int                pending;
  int                bytes_checked;
  int                sent_per_cmd [4];

  seven_segment_display_command_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  seven_segment_display_command_encoder_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req        (in_req),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_rsp       (out_rsp),
    .drain         (drain),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ssd_pkg::in_req_t make_req(input logic [1:0] cmd, input int num,
                                                input int code, input int pos,
                                                input int lvl);
    ssd_pkg::in_req_t r;
    r.command    = cmd;
    r.number     = 16'(num);
    r.digit_code = 8'(code);
    r.position   = 8'(pos);
    r.level      = 8'(lvl);
    return r;
  endfunction

  function automatic ssd_pkg::in_req_t random_req();
    ssd_pkg::in_req_t r;
    r.command = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: r.number = 16'($urandom);
      1: r.number = 16'($urandom_range(9999));
      2: r.number = 16'(32'd0 - $urandom_range(1200, 1));
      default: r.number = $urandom_range(1) ? 16'(32'd9995 + $urandom_range(10))
                                            : 16'(32'h8000 + $urandom_range(3));
    endcase
    r.digit_code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24));
    r.position   = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.level      = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(9));
    return r;
  endfunction

  task automatic send_request(input ssd_pkg::in_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sent_per_cmd[r.command]++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // hold on so that a stray byte still in the pipeline reaches the checker
    repeat (16) @(posedge clk);
  endtask

  task automatic write_colon(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct);
    ssd_pkg::in_req_t r;
    int               n;
    n = 0;
    while (n < count) begin
      r = random_req();
      send_request(r, idle_pct);
      if (!(r.command == ssd_pkg::CMD_DIGIT && r.position > 8'd3)) n++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    drain     = 1'b0;
    for (int i = 0; i < 4; i++) sent_per_cmd[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_colon(1'b0);

    send_request(make_req(ssd_pkg::CMD_CLEAR, 16'h7fff, 255, 255, 255), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 0, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 9999, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 10000, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 32767, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, -1, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, -999, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, -1000, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, -32768, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 1234, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 20, 3, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 21, 2, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 255, 1, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 8, 4, 0), 19);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 8, 255, 0), 19);
    send_request(make_req(ssd_pkg::CMD_BRIGHT, 0, 0, 0, 0), 19);
    send_request(make_req(ssd_pkg::CMD_BRIGHT, 0, 0, 0, 7), 19);
    send_request(make_req(ssd_pkg::CMD_BRIGHT, 0, 0, 0, 8), 19);
    send_request(make_req(ssd_pkg::CMD_BRIGHT, -1, 255, 255, 255), 19);
    wait_idle();

    write_colon(1'b1);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, 5678, 0, 0, 0), 0);
    send_request(make_req(ssd_pkg::CMD_DECIMAL, -42, 0, 0, 0), 0);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 8, 1, 0), 0);
    send_request(make_req(ssd_pkg::CMD_DIGIT, 0, 8, 0, 0), 0);
    send_request(make_req(ssd_pkg::CMD_CLEAR, 0, 0, 0, 0), 0);
    wait_idle();

    write_colon(1'b0);
    run_random(60, 19);
    wait_idle();
    write_colon(1'b1);
    run_random(60, 46);
    wait_idle();
    write_colon(1'($urandom_range(1)));
    run_random(55, 0);
    wait_idle();

    drain <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Ran %0d requests: %0d clear, %0d decimal, %0d digit, %0d brightness",
             sent_per_cmd[0] + sent_per_cmd[1] + sent_per_cmd[2] + sent_per_cmd[3],
             sent_per_cmd[0], sent_per_cmd[1], sent_per_cmd[2], sent_per_cmd[3]);
    $display("Checked %0d display bytes with the colon both off and on", bytes_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ssd_pkg.sv
hdl/ssd_frame_pipe.sv
hdl/seven_segment_display_command_encoder.sv
tb/seven_segment_display_command_encoder_checker.sv
tb/seven_segment_display_command_encoder_test.sv
